// File: sv/gtpf_pkg.sv
// Package for the gap-timed packet framer queue.
// Holds field widths, codes and the command and status groups shared by the controller and datapath.
package gtpf_pkg;

	localparam int WORD_W   = 32;
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 7;
	localparam int POS_W    = 6;
	localparam int CFG_IDX_W = 2;

	localparam int QUEUE_SLOTS_DEF = 16;
	localparam int MAX_PACKET_DEF  = 64;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_TICKS = 2'd1;

	typedef struct packed {
		logic rx_byte_en;
		logic pop_start;
		logic emit_byte;
		logic emit_empty;
		logic pop_done;
	} cmd_t;

	typedef struct packed {
		logic queue_empty;
		logic pkt_last;
		logic out_free;
	} status_t;

endpackage

// File: sv/gtpf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gtpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/gtpf_ctrl.sv
// Controller state machine of the packet framer queue.
// Uses gtpf_pkg for the command and status groups.
module gtpf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  gtpf_pkg::status_t status,
	output gtpf_pkg::cmd_t    cmd
);
	import gtpf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DATA   = 3'b010,
		ST_EMPTYQ = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (op == OP_BYTE) begin
						cmd.rx_byte_en = 1'b1;
					end else if (status.queue_empty) begin
						state_d = ST_EMPTYQ;
					end else begin
						cmd.pop_start = 1'b1;
						state_d       = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				if (status.out_free) begin
					cmd.emit_byte = 1'b1;
					if (status.pkt_last) begin
						cmd.pop_done = 1'b1;
						state_d      = ST_IDLE;
					end
				end
			end
			ST_EMPTYQ: begin
				if (status.out_free) begin
					cmd.emit_empty = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: sv/gtpf_dp.sv
// Datapath of the packet framer queue: configuration, framing registers, slot memories
// and the output register. Uses gtpf_pkg and instantiates gtpf_ram.
module gtpf_dp #(
	parameter int QUEUE_SLOTS = gtpf_pkg::QUEUE_SLOTS_DEF,
	parameter int MAX_PACKET  = gtpf_pkg::MAX_PACKET_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gtpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gtpf_pkg::WORD_W-1:0]    cfg_data,
	input  logic [gtpf_pkg::BYTE_W-1:0]    rx_byte,
	input  logic [gtpf_pkg::WORD_W-1:0]    arrival_time,
	input  gtpf_pkg::cmd_t                 cmd,
	output gtpf_pkg::status_t              status,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           queue_empty,
	output logic [gtpf_pkg::WORD_W-1:0]    packet_seq,
	output logic [gtpf_pkg::WORD_W-1:0]    packet_start,
	output logic [gtpf_pkg::LEN_W-1:0]     packet_len,
	output logic [gtpf_pkg::POS_W-1:0]     byte_pos,
	output logic [gtpf_pkg::BYTE_W-1:0]    data_byte,
	output logic                           last,
	output logic [gtpf_pkg::WORD_W-1:0]    drops
);
	import gtpf_pkg::*;

	localparam int SW         = $clog2(QUEUE_SLOTS);
	localparam int PW         = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
	localparam int BYTE_DEPTH = QUEUE_SLOTS * (2 ** PW);
	localparam int META_W     = LEN_W + 2 * WORD_W;
	localparam logic [SW-1:0]    LAST_SLOT = SW'(QUEUE_SLOTS - 1);
	localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_PACKET);

	logic [WORD_W-1:0] gap_limit_q, byte_ticks_q;
	logic [SW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [WORD_W-1:0] seq_q, prev_time_q, drops_q;
	logic [LEN_W-1:0]  open_len_q;
	logic [WORD_W-1:0] open_seq_q, open_start_q;
	logic [PW-1:0]     pos_q;
	logic              out_valid_q;

	logic [WORD_W-1:0] gap;
	logic              new_pkt, ring_full, meta_we, out_load;
	logic [SW-1:0]     wr_next, rd_next, wr_slot;
	logic [PW-1:0]     wr_pos, rd_pos;
	logic [META_W-1:0] meta_rdata;
	logic [BYTE_W-1:0] byte_rdata;
	logic [LEN_W-1:0]  m_len;
	logic [WORD_W-1:0] m_seq, m_start;

	assign gap       = arrival_time - prev_time_q;
	assign new_pkt   = (open_len_q >= MAX_LEN) || (gap > gap_limit_q);
	assign wr_next   = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next   = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
	assign ring_full = (wr_next == rd_ptr_q);
	assign meta_we   = cmd.rx_byte_en && new_pkt && !ring_full;
	assign wr_slot   = meta_we ? wr_next : wr_ptr_q;
	assign wr_pos    = new_pkt ? '0 : open_len_q[PW-1:0];
	assign rd_pos    = cmd.pop_start ? '0 : pos_q + 1'b1;

	assign m_len   = meta_rdata[META_W-1 -: LEN_W];
	assign m_seq   = meta_rdata[2*WORD_W-1 -: WORD_W];
	assign m_start = meta_rdata[WORD_W-1:0];

	assign status.queue_empty = (wr_ptr_q == rd_ptr_q);
	assign status.pkt_last    = (m_len == '0) || (LEN_W'(pos_q) + 1'b1 == m_len);
	assign status.out_free    = !out_valid_q || !out_stall;
	assign out_load           = cmd.emit_byte || cmd.emit_empty;
	assign out_valid          = out_valid_q;

	gtpf_ram #(
		.WIDTH(META_W),
		.DEPTH(QUEUE_SLOTS)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(wr_ptr_q),
		.wdata({open_len_q, open_seq_q, open_start_q}),
		.re   (cmd.pop_start),
		.raddr(rd_ptr_q),
		.rdata(meta_rdata)
	);

	gtpf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BYTE_DEPTH)
	) u_byte_ram (
		.clk  (clk),
		.we   (cmd.rx_byte_en),
		.waddr({wr_slot, wr_pos}),
		.wdata(rx_byte),
		.re   (cmd.pop_start || cmd.emit_byte),
		.raddr({rd_ptr_q, rd_pos}),
		.rdata(byte_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q  <= '0;
			byte_ticks_q <= '0;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			seq_q        <= '0;
			prev_time_q  <= '0;
			drops_q      <= '0;
			open_len_q   <= '0;
			open_seq_q   <= '0;
			open_start_q <= '0;
			pos_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_GAP_LIMIT) begin
				gap_limit_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_BYTE_TICKS) begin
				byte_ticks_q <= cfg_data;
			end
			if (cmd.rx_byte_en) begin
				prev_time_q <= arrival_time;
				if (new_pkt) begin
					if (ring_full) begin
						drops_q <= drops_q + 1'b1;
					end else begin
						wr_ptr_q <= wr_next;
					end
					seq_q        <= seq_q + 1'b1;
					open_seq_q   <= seq_q + 1'b1;
					open_start_q <= arrival_time - byte_ticks_q;
					open_len_q   <= LEN_W'(1);
				end else begin
					open_len_q <= open_len_q + 1'b1;
				end
			end
			if (cmd.pop_start) begin
				pos_q <= '0;
			end else if (cmd.emit_byte) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.pop_done) begin
				rd_ptr_q <= rd_next;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			drops <= drops_q;
			last  <= cmd.emit_empty || status.pkt_last;
			if (cmd.emit_empty) begin
				queue_empty  <= 1'b1;
				packet_seq   <= '0;
				packet_start <= '0;
				packet_len   <= '0;
				byte_pos     <= '0;
				data_byte    <= '0;
			end else begin
				queue_empty  <= 1'b0;
				packet_seq   <= m_seq;
				packet_start <= m_start;
				packet_len   <= m_len;
				byte_pos     <= POS_W'(pos_q);
				data_byte    <= (m_len == '0) ? '0 : byte_rdata;
			end
		end
	end

endmodule

// File: sv/gap_timed_packet_framer_queue.sv
// Top level of the gap-timed packet framer queue: controller and datapath.
// Uses gtpf_pkg; instantiates gtpf_ctrl and gtpf_dp.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid / in_stall    op, rx_byte, arrival_time
//   output    out        out_valid / out_stall  queue_empty .. drops, one beat per byte
//   config    in         cfg_we                 cfg_index, cfg_data
//
// A received byte is taken while idle and does not stall. A pop reads the slot header and
// the first byte, then gives the result beats while the output register is free, paced by
// the registered read of the slot memories; an empty queue pop gives one beat. A result
// waits in the output register while the next item is taken. Reset clears all control
// state at once; slot headers are written when a slot closes, so no clearing pass is run.
module gap_timed_packet_framer_queue #(
	parameter int QUEUE_SLOTS = gtpf_pkg::QUEUE_SLOTS_DEF,
	parameter int MAX_PACKET  = gtpf_pkg::MAX_PACKET_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gtpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gtpf_pkg::WORD_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [gtpf_pkg::BYTE_W-1:0]    rx_byte,
	input  logic [gtpf_pkg::WORD_W-1:0]    arrival_time,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           queue_empty,
	output logic [gtpf_pkg::WORD_W-1:0]    packet_seq,
	output logic [gtpf_pkg::WORD_W-1:0]    packet_start,
	output logic [gtpf_pkg::LEN_W-1:0]     packet_len,
	output logic [gtpf_pkg::POS_W-1:0]     byte_pos,
	output logic [gtpf_pkg::BYTE_W-1:0]    data_byte,
	output logic                           last,
	output logic [gtpf_pkg::WORD_W-1:0]    drops
);
	import gtpf_pkg::*;

	cmd_t    cmd;
	status_t status;

	gtpf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op      (op),
		.status  (status),
		.cmd     (cmd)
	);

	gtpf_dp #(
		.QUEUE_SLOTS(QUEUE_SLOTS),
		.MAX_PACKET (MAX_PACKET)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rx_byte     (rx_byte),
		.arrival_time(arrival_time),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.queue_empty (queue_empty),
		.packet_seq  (packet_seq),
		.packet_start(packet_start),
		.packet_len  (packet_len),
		.byte_pos    (byte_pos),
		.data_byte   (data_byte),
		.last        (last),
		.drops       (drops)
	);

endmodule

// File: tb/sv/gap_timed_packet_framer_queue_checker.sv
// Checker for the gap-timed packet framer queue: follows register writes and input beats,
// predicts every result beat and compares each accepted one field by field.
// Depends on gtpf_pkg for widths, operation codes and register indexes.
module gap_timed_packet_framer_queue_checker #(
	parameter int QUEUE_SLOTS = gtpf_pkg::QUEUE_SLOTS_DEF,
	parameter int MAX_PACKET  = gtpf_pkg::MAX_PACKET_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gtpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gtpf_pkg::WORD_W-1:0]    cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           op,
	input  logic [gtpf_pkg::BYTE_W-1:0]    rx_byte,
	input  logic [gtpf_pkg::WORD_W-1:0]    arrival_time,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           queue_empty,
	input  logic [gtpf_pkg::WORD_W-1:0]    packet_seq,
	input  logic [gtpf_pkg::WORD_W-1:0]    packet_start,
	input  logic [gtpf_pkg::LEN_W-1:0]     packet_len,
	input  logic [gtpf_pkg::POS_W-1:0]     byte_pos,
	input  logic [gtpf_pkg::BYTE_W-1:0]    data_byte,
	input  logic                           last,
	input  logic [gtpf_pkg::WORD_W-1:0]    drops,
	output int                             errors,
	output int                             pending,
	output int                             beats_checked,
	output int                             items_checked,
	output logic [gtpf_pkg::WORD_W-1:0]    drop_total
);
	import gtpf_pkg::*;

	typedef struct packed {
		logic              queue_empty;
		logic [WORD_W-1:0] packet_seq;
		logic [WORD_W-1:0] packet_start;
		logic [LEN_W-1:0]  packet_len;
		logic [POS_W-1:0]  byte_pos;
		logic [BYTE_W-1:0] data_byte;
		logic              last;
		logic [WORD_W-1:0] drops;
	} beat_t;

	beat_t             pending_beats[$];
	logic [BYTE_W-1:0] slot_data[QUEUE_SLOTS*MAX_PACKET];
	logic [LEN_W-1:0]  slot_fill[QUEUE_SLOTS];
	logic [WORD_W-1:0] slot_seq_no[QUEUE_SLOTS];
	logic [WORD_W-1:0] slot_t0[QUEUE_SLOTS];
	int unsigned       open_slot;
	int unsigned       oldest_slot;
	logic [WORD_W-1:0] seq_next;
	logic [WORD_W-1:0] last_arrival;
	logic [WORD_W-1:0] drop_count;
	logic [WORD_W-1:0] gap_limit;
	logic [WORD_W-1:0] char_ticks;
	int                fails;
	int                beats_done;
	int                items_done;

	function automatic int unsigned queued_packets();
		return (open_slot + QUEUE_SLOTS - oldest_slot) % QUEUE_SLOTS;
	endfunction

	task automatic add_beat(input logic empty, input logic [WORD_W-1:0] seq,
			input logic [WORD_W-1:0] t0, input logic [LEN_W-1:0] len,
			input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] data, input logic fin);
		beat_t b;
		b.queue_empty  = empty;
		b.packet_seq   = seq;
		b.packet_start = t0;
		b.packet_len   = len;
		b.byte_pos     = pos;
		b.data_byte    = data;
		b.last         = fin;
		b.drops        = drop_count;
		pending_beats.push_back(b);
	endtask

	// A byte joins the open packet unless the gap or a full packet starts a new one.
	task automatic frame_byte(input logic [BYTE_W-1:0] b, input logic [WORD_W-1:0] t);
		logic [WORD_W-1:0] gap;
		int unsigned w;
		int unsigned fill;
		gap = t - last_arrival;
		w = open_slot;
		fill = int'(slot_fill[w]);
		last_arrival = t;
		if (fill >= MAX_PACKET || gap > gap_limit) begin
			if (queued_packets() < QUEUE_SLOTS - 1) begin
				w = (w + 1) % QUEUE_SLOTS;
				open_slot = w;
			end else begin
				drop_count = drop_count + 1;
			end
			seq_next = seq_next + 1;
			slot_seq_no[w] = seq_next;
			slot_t0[w] = t - char_ticks;
			fill = 0;
		end
		slot_data[w * MAX_PACKET + fill] = b;
		slot_fill[w] = LEN_W'(fill + 1);
	endtask

	task automatic pop_packet();
		int unsigned r;
		int unsigned fill;
		if (queued_packets() == 0) begin
			add_beat(1'b1, '0, '0, '0, '0, '0, 1'b1);
		end else begin
			r = oldest_slot;
			fill = int'(slot_fill[r]);
			oldest_slot = (r + 1) % QUEUE_SLOTS;
			if (fill == 0) begin
				add_beat(1'b0, slot_seq_no[r], slot_t0[r], '0, '0, '0, 1'b1);
			end else begin
				for (int i = 0; i < fill; i++)
					add_beat(1'b0, slot_seq_no[r], slot_t0[r], LEN_W'(fill), POS_W'(i),
						slot_data[r * MAX_PACKET + i], i + 1 == fill);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		beat_t want;
		if (!arst_n) begin
			pending_beats.delete();
			for (int i = 0; i < QUEUE_SLOTS; i++) begin
				slot_fill[i] = '0;
				slot_seq_no[i] = '0;
				slot_t0[i] = '0;
			end
			for (int i = 0; i < QUEUE_SLOTS * MAX_PACKET; i++)
				slot_data[i] = '0;
			open_slot = 0;
			oldest_slot = 0;
			seq_next = '0;
			last_arrival = '0;
			drop_count = '0;
			gap_limit = '0;
			char_ticks = '0;
			fails = 0;
			beats_done = 0;
			items_done = 0;
			errors <= 0;
			pending <= 0;
			beats_checked <= 0;
			items_checked <= 0;
			drop_total <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				beats_done++;
				if (pending_beats.size() == 0) begin
					fails++;
					$display("%0t: result beat with none pending, expected none, actual seq %0h pos %0d",
						$time, packet_seq, byte_pos);
				end else begin
					want = pending_beats.pop_front();
					check_field("queue_empty", WORD_W'(want.queue_empty), WORD_W'(queue_empty));
					check_field("packet_seq", want.packet_seq, packet_seq);
					check_field("packet_start", want.packet_start, packet_start);
					check_field("packet_len", WORD_W'(want.packet_len), WORD_W'(packet_len));
					check_field("byte_pos", WORD_W'(want.byte_pos), WORD_W'(byte_pos));
					check_field("data_byte", WORD_W'(want.data_byte), WORD_W'(data_byte));
					check_field("last", WORD_W'(want.last), WORD_W'(last));
					check_field("drops", want.drops, drops);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_GAP_LIMIT: gap_limit = cfg_data;
					REG_BYTE_TICKS: char_ticks = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				items_done++;
				if (op == OP_POP)
					pop_packet();
				else
					frame_byte(rx_byte, arrival_time);
			end
			errors <= fails;
			pending <= pending_beats.size();
			beats_checked <= beats_done;
			items_checked <= items_done;
			drop_total <= drop_count;
		end
	end

endmodule

// File: tb/sv/gap_timed_packet_framer_queue_tb.sv
// Testbench top for the gap-timed packet framer queue: clock, reset, register writes,
// input beats and output stalls. Depends on gtpf_pkg, the block and its checker module.
module gap_timed_packet_framer_queue_tb;
	import gtpf_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_GAP_LIMIT;
	logic [WORD_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 op = OP_BYTE;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic [WORD_W-1:0]    arrival_time = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 queue_empty;
	logic [WORD_W-1:0]    packet_seq;
	logic [WORD_W-1:0]    packet_start;
	logic [LEN_W-1:0]     packet_len;
	logic [POS_W-1:0]     byte_pos;
	logic [BYTE_W-1:0]    data_byte;
	logic                 last;
	logic [WORD_W-1:0]    drops;

	int                   errors;
	int                   pending;
	int                   beats_checked;
	int                   items_checked;
	logic [WORD_W-1:0]    drop_total;

	logic                 gap_idle = 1'b0;
	logic                 stall_idle = 1'b0;
	logic                 hold_req = 1'b0;
	logic [WORD_W-1:0]    now = '0;
	logic [WORD_W-1:0]    cur_gap = '0;
	int                   items_sent = 0;

	gap_timed_packet_framer_queue dut (.*);

	gap_timed_packet_framer_queue_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// The receiver stalls at random, or for a long stretch when asked to.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req)
				hold_left = 300;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= stall_idle && ($urandom_range(99) < 30);
			end
		end
	end

	task automatic send_item(input logic kind, input logic [BYTE_W-1:0] b,
			input logic [WORD_W-1:0] t);
		while (gap_idle && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		rx_byte <= b;
		arrival_time <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic byte_at(input logic [BYTE_W-1:0] b, input logic [WORD_W-1:0] t);
		now = t;
		send_item(OP_BYTE, b, t);
	endtask

	task automatic send_byte(input logic [WORD_W-1:0] delta);
		byte_at(BYTE_W'($urandom_range(255)), now + delta);
	endtask

	task automatic pop_queue();
		send_item(OP_POP, BYTE_W'($urandom_range(255)), $urandom);
	endtask

	function automatic logic [WORD_W-1:0] short_gap();
		if ($urandom_range(3) == 0)
			return cur_gap;
		return $urandom_range(cur_gap, 0);
	endfunction

	function automatic logic [WORD_W-1:0] long_gap();
		logic [WORD_W-1:0] room;
		room = ~cur_gap;
		if (room == 0)
			return $urandom;
		if ($urandom_range(3) == 0)
			return cur_gap + 1;
		return cur_gap + 1 + ($urandom % room);
	endfunction

	task automatic set_config(input logic [WORD_W-1:0] g, input logic [WORD_W-1:0] t);
		cfg_we <= 1'b1;
		cfg_index <= $urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_index <= REG_GAP_LIMIT;
		cfg_data <= g;
		@(posedge clk);
		cfg_index <= REG_BYTE_TICKS;
		cfg_data <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_gap = g;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Mostly whole packets of random bytes, with pops, ring floods and stray timestamps.
	task automatic run_phase(input int n_items);
		int start;
		int pick;
		int len;
		start = items_sent;
		while (items_sent - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : $urandom_range(6, 1);
				send_byte(long_gap());
				repeat (len - 1) send_byte(short_gap());
			end else if (pick < 85) begin
				repeat ($urandom_range(3, 1)) pop_queue();
			end else if (pick < 93) begin
				repeat ($urandom_range(19, 16)) send_byte(long_gap());
			end else begin
				send_byte($urandom);
			end
		end
	endtask

	initial begin
		logic [WORD_W-1:0] first_t;
		first_t = $urandom_range(1) ? 32'd0 : 32'd7;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_idle <= 1'b1;
		stall_idle <= 1'b1;

		// Register values after reset: the first byte either joins slot zero or closes it empty.
		pop_queue();
		byte_at(8'h00, first_t);
		byte_at(8'hFF, first_t);
		byte_at(8'h5A, first_t + 1);
		repeat (3) pop_queue();
		drain();

		// Gaps at the limit and one past it, start times and gaps that wrap.
		set_config(32'd3, 32'hFFFF_FFFF);
		byte_at(8'h81, 32'hFFFF_FFF0);
		byte_at(8'h7E, 32'hFFFF_FFF3);
		byte_at(8'h01, 32'hFFFF_FFF7);
		byte_at(8'h80, 32'hFFFF_FFFF);
		byte_at(8'hC3, 32'h0000_0001);
		repeat (4) pop_queue();
		drain();

		set_config($urandom_range(40, 8), $urandom_range(1000, 0));
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		run_phase(40);
		drain();

		gap_idle <= 1'b0;
		stall_idle <= 1'b0;
		set_config('0, '0);
		run_phase(40);
		drain();

		// No gap can exceed the limit, so only a full packet closes one.
		gap_idle <= 1'b1;
		stall_idle <= 1'b1;
		set_config('1, '1);
		repeat (70) send_byte($urandom);
		repeat (16) pop_queue();
		drain();

		set_config($urandom, $urandom);
		run_phase(40);
		drain();

		$display("Run covered %0d input beats and %0d result beats over six register settings.",
			items_checked, beats_checked);
		$display("Ring overflow dropped %0d packets in total.", drop_total);
		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
sv/gtpf_pkg.sv
sv/gtpf_ram.sv
sv/gtpf_ctrl.sv
sv/gtpf_dp.sv
sv/gap_timed_packet_framer_queue.sv
tb/sv/gap_timed_packet_framer_queue_checker.sv
tb/sv/gap_timed_packet_framer_queue_tb.sv
